@@ hdl/assert_macros.svh @@
// assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/pcm_pkg.sv @@
package pcm_pkg;

  localparam int LIMBS_DEF = 6;
  localparam int MAX_N_DEF = 60;

  localparam int N_W     = 6;
  localparam int LIMB_W  = 54;
  localparam int PROD_W  = 60;
  localparam int Q_W     = 6;
  localparam int IDX_W   = 3;
  localparam int IN_TW   = 16;
  localparam int OUT_TW  = 64;

  localparam logic [LIMB_W-1:0] LIMB_BASE = 54'd10000000000000000;

  // quotient estimate: q ~= (prod >> EST_LSB) * RECIP >> RECIP_SHIFT, low by at most 1
  localparam int EST_LSB     = 40;
  localparam int EST_IN_W    = PROD_W - EST_LSB;
  localparam int EST_W       = 31;
  localparam int RECIP_SHIFT = 24;
  localparam logic [10:0] RECIP = 11'd1844;

endpackage

@@ hdl/permutation_count_multilimb_top.sv @@
// Falling factorial A(n,k) = n*(n-1)*...*(n-k+1) as base 10^16 limbs.
// Input channel (in_*): one beat carries n and k. n above MAX_N saturates.
// n = 0 or k = 0 gives 1; k > n gives 0.
// Result channel (out_*): one beat per limb in use, least significant first,
// with its index, the top limb index, and tlast on the most significant limb.
// Timing: in_tready is high only while idle. Each factor multiplies every
// limb in use through one shared multiply / quotient-estimate / correct unit,
// one limb after another in the multiply, estimate, remainder and fix states.
// Special cases (n = 0, k = 0 or k > n) go straight to emitting one limb.
// Limbs go out through a single output register; when the receiver stalls
// the sequencer holds the next limb until out_tready frees the register.
// A new input is taken as soon as the last limb is loaded into it.
// Reset (rst_n low, synchronous) returns to idle and drops any pending beat.
// Limb storage is not cleared at reset; every entry is written before read.
module permutation_count_multilimb_top #(
  parameter int LIMBS = pcm_pkg::LIMBS_DEF,
  parameter int MAX_N = pcm_pkg::MAX_N_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pcm_pkg::IN_TW-1:0] in_tdata,   // n[5:0], k[11:6]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [pcm_pkg::OUT_TW-1:0] out_tdata, // limb_index[2:0], limb_value[56:3], top_limb[59:57]
  output logic                      out_tlast   // is_last
);
  import pcm_pkg::*;

  localparam int IW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int CW = $clog2(LIMBS + 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_EST, S_REM, S_FIX, S_EMIT} state_t;

  state_t              state_r;
  logic [LIMB_W-1:0]   store_r [LIMBS];
  logic [CW-1:0]       count_r;
  logic [IW-1:0]       idx_r;
  logic [N_W-1:0]      n_r;
  logic [N_W-1:0]      k_r;
  logic [Q_W-1:0]      carry_r;
  logic [PROD_W-1:0]   prod_r;
  logic [Q_W-1:0]      qest_r;
  logic [PROD_W-1:0]   rem_r;

  logic                out_tvalid_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [LIMB_W-1:0]   out_value_r;
  logic [IDX_W-1:0]    out_top_r;
  logic                out_last_r;

  logic [N_W-1:0]      in_n;
  logic [N_W-1:0]      in_k;
  logic [N_W-1:0]      n_sat;
  logic                accept;
  logic [EST_W-1:0]    est_full;
  logic                over;
  logic [LIMB_W-1:0]   limb_fix;
  logic [Q_W-1:0]      q_fix;
  logic                idx_top;
  logic                out_free;

  assign in_n     = in_tdata[N_W-1:0];
  assign in_k     = in_tdata[2*N_W-1:N_W];
  assign n_sat    = (in_n > N_W'(MAX_N)) ? N_W'(MAX_N) : in_n;
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;

  assign est_full = EST_W'(prod_r[PROD_W-1:EST_LSB]) * EST_W'(RECIP);
  assign over     = (rem_r >= PROD_W'(LIMB_BASE));
  assign limb_fix = over ? LIMB_W'(rem_r - PROD_W'(LIMB_BASE)) : LIMB_W'(rem_r);
  assign q_fix    = over ? (qest_r + Q_W'(1)) : qest_r;
  assign idx_top  = (CW'(idx_r) == (count_r - CW'(1)));
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_EMIT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r   <= '0;
            count_r <= CW'(1);
            carry_r <= '0;
            n_r     <= n_sat;
            k_r     <= in_k;
            if (n_sat == '0 || in_k == '0) begin
              store_r[0] <= LIMB_W'(1);
              state_r    <= S_EMIT;
            end else if (in_k > n_sat) begin
              store_r[0] <= '0;
              state_r    <= S_EMIT;
            end else begin
              store_r[0] <= LIMB_W'(1);
              state_r    <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(store_r[idx_r]) * PROD_W'(n_r) + PROD_W'(carry_r);
          state_r <= S_EST;
        end
        S_EST: begin
          qest_r  <= est_full[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
          state_r <= S_REM;
        end
        S_REM: begin
          rem_r   <= prod_r - PROD_W'(qest_r) * PROD_W'(LIMB_BASE);
          state_r <= S_FIX;
        end
        S_FIX: begin
          store_r[idx_r] <= limb_fix;
          if (idx_top) begin
            // factor done: open a new limb on carry out of the top if one is free
            if (q_fix != '0 && count_r < CW'(LIMBS)) begin
              store_r[count_r[IW-1:0]] <= LIMB_W'(q_fix);
              count_r                  <= count_r + CW'(1);
            end
            n_r     <= n_r - N_W'(1);
            k_r     <= k_r - N_W'(1);
            idx_r   <= '0;
            carry_r <= '0;
            state_r <= (k_r == N_W'(1)) ? S_EMIT : S_MUL;
          end else begin
            carry_r <= q_fix;
            idx_r   <= idx_r + IW'(1);
            state_r <= S_MUL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_index_r  <= IDX_W'(idx_r);
            out_value_r  <= store_r[idx_r];
            out_top_r    <= IDX_W'(count_r - CW'(1));
            out_last_r   <= idx_top;
            if (idx_top) begin
              idx_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + IW'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TW - 2*IDX_W - LIMB_W){1'b0}}, out_top_r, out_value_r, out_index_r};

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_est_low_by_one, clk, rst_n, state_r == S_FIX, rem_r < 2 * PROD_W'(LIMB_BASE))
  `ASSERT_IMPLIES(a_count_range, clk, rst_n, state_r != S_IDLE, count_r >= CW'(1) && count_r <= CW'(LIMBS))
  `ASSERT_IMPLIES(a_mul_operands, clk, rst_n, state_r == S_MUL, CW'(idx_r) < count_r && carry_r <= Q_W'(MAX_N) && k_r != '0)
  `ASSERT_NEXT(a_fix_limb_bound, clk, rst_n, state_r == S_FIX, store_r[$past(idx_r)] < LIMB_BASE)

endmodule
